FILE: rtl/rspa_pkg.sv
package rspa_pkg;

    typedef struct packed {
        logic [27:0] col;
        logic [13:0] row;
    } t_in;

    typedef struct packed {
        logic [13:0] raw_col;
        logic [13:0] raw_row;
        logic [27:0] raw_index;
        logic [28:0] scaled_width;
        logic        in_range;
    } t_out;

    typedef enum logic [1:0] {
        WC_LOAD,
        WC_RUN,
        WC_DONE
    } t_wc_state;

    localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_TURN          = 2'd2;
    localparam logic [1:0] REG_SCALED_HEIGHT = 2'd3;

    localparam logic [1:0] TURN_NONE = 2'd0;
    localparam logic [1:0] TURN_90   = 2'd1;
    localparam logic [1:0] TURN_180  = 2'd2;
    localparam logic [1:0] TURN_270  = 2'd3;

    localparam int SW_W = 29;

endpackage

FILE: rtl/rotate_scale_pixel_address_top.sv
// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_ready  i_in_data  (rspa_pkg::t_in)
// output    out        o_out_valid / i_out_ready o_out_data (rspa_pkg::t_out)
// config    in         i_cfg_we                 i_cfg_index, i_cfg_data
//
// One transaction is accepted per cycle while the output is not stalled and the serial
// width divider is idle. The two nearest-neighbour divisions are one-bit-per-stage
// quotient pipelines. After reset and after every configuration write the output width
// is recomputed by that serial divider, with o_in_ready low.
// A stall on the output holds every stage in place.
module rotate_scale_pixel_address_top #(
    parameter int MAX_DIM = 16384
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [14:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rspa_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rspa_pkg::t_out o_out_data
);
    import rspa_pkg::*;

    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int QB = $clog2(MAX_DIM);
    localparam int NXW = 28 + DW;
    localparam int NYW = 14 + DW;

    logic [14:0] r_frame_width, r_frame_height, r_scaled_height;
    logic [1:0]  r_turn;

    logic [DW-1:0] w_w, w_h, w_th, w_ow, w_oh;
    logic          w_quarter;
    logic [SW_W-1:0] w_sw;
    logic          w_busy;
    logic          w_en;

    function automatic logic [DW-1:0] clamp_dim(input logic [14:0] v);
        logic [DW-1:0] res;
        if (v == '0) begin
            res = DW'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = DW'(MAX_DIM);
        end else begin
            res = DW'(v);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= 15'd1920;
            r_frame_height  <= 15'd1080;
            r_turn          <= TURN_NONE;
            r_scaled_height <= 15'd1080;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                REG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                REG_TURN:          r_turn          <= i_cfg_data[1:0];
                REG_SCALED_HEIGHT: r_scaled_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_w       = clamp_dim(r_frame_width);
    assign w_h       = clamp_dim(r_frame_height);
    assign w_th      = clamp_dim(r_scaled_height);
    assign w_quarter = (r_turn == TURN_90) || (r_turn == TURN_270);
    assign w_ow      = w_quarter ? w_h : w_w;
    assign w_oh      = w_quarter ? w_w : w_h;

    rspa_width_calc #(.DW(DW)) u_width (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_ow    (w_ow),
        .i_oh    (w_oh),
        .i_th    (w_th),
        .o_sw    (w_sw),
        .o_busy  (w_busy)
    );

    logic r_out_valid;
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en && !w_busy;

    logic           r1_valid, r1_inr;
    logic [NXW-1:0] r1_nx;
    logic [NYW-1:0] r1_ny;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_in_valid && o_in_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_nx  <= NXW'(i_in_data.col) * NXW'(w_ow);
            r1_ny  <= NYW'(i_in_data.row) * NYW'(w_oh);
            r1_inr <= (29'(i_in_data.col) < w_sw) && (DW'(i_in_data.row) < w_th);
        end
    end

    logic          w_xv, w_yv, w_xtag, w_ytag;
    logic [QB-1:0] w_qx, w_qy;

    rspa_div_pipe #(.NW(NXW), .DVW(SW_W), .QB(QB)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_valid),
        .i_tag   (r1_inr),
        .i_num   (r1_nx),
        .i_den   (w_sw),
        .o_valid (w_xv),
        .o_tag   (w_xtag),
        .o_quot  (w_qx)
    );

    rspa_div_pipe #(.NW(NYW), .DVW(DW), .QB(QB)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_valid),
        .i_tag   (r1_inr),
        .i_num   (r1_ny),
        .i_den   (w_th),
        .o_valid (w_yv),
        .o_tag   (w_ytag),
        .o_quot  (w_qy)
    );

    logic [DW-1:0] w_sx, w_sy, n_rx, n_ry;
    logic [DW-1:0] w_owm1, w_ohm1;

    assign w_owm1 = w_ow - 1'b1;
    assign w_ohm1 = w_oh - 1'b1;
    assign w_sx   = (DW'(w_qx) > w_owm1) ? w_owm1 : DW'(w_qx);
    assign w_sy   = (DW'(w_qy) > w_ohm1) ? w_ohm1 : DW'(w_qy);

    always_comb begin
        case (r_turn)
            TURN_90: begin
                n_rx = w_sy;
                n_ry = w_h - 1'b1 - w_sx;
            end
            TURN_180: begin
                n_rx = w_w - 1'b1 - w_sx;
                n_ry = w_h - 1'b1 - w_sy;
            end
            TURN_270: begin
                n_rx = w_w - 1'b1 - w_sy;
                n_ry = w_sx;
            end
            default: begin
                n_rx = w_sx;
                n_ry = w_sy;
            end
        endcase
    end

    logic          r2_valid, r2_inr;
    logic [DW-1:0] r2_rx, r2_ry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= w_xv && w_yv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_rx  <= n_rx;
            r2_ry  <= n_ry;
            r2_inr <= w_xtag && w_ytag;
        end
    end

    t_out r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data.raw_col      <= 14'(r2_rx);
            r_out_data.raw_row      <= 14'(r2_ry);
            r_out_data.raw_index    <= 28'((2 * DW)'(r2_ry) * (2 * DW)'(w_w)
                                           + (2 * DW)'(r2_rx));
            r_out_data.scaled_width <= w_sw;
            r_out_data.in_range     <= r2_inr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/rspa_width_calc.sv
module rspa_width_calc #(
    parameter int DW = 15
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [DW-1:0]            i_ow,
    input  logic [DW-1:0]            i_oh,
    input  logic [DW-1:0]            i_th,
    output logic [rspa_pkg::SW_W-1:0] o_sw,
    output logic                     o_busy
);
    import rspa_pkg::*;

    localparam int NUM_W = 2 * DW + 2;
    localparam int REM_W = DW + 2;
    localparam int CNT_W = $clog2(NUM_W);

    t_wc_state r_state, n_state;
    logic [NUM_W-1:0] r_num, n_num;
    logic [NUM_W-1:0] r_quot, n_quot;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [REM_W-1:0] w_den;
    logic [REM_W-1:0] w_trial;

    assign w_den   = {1'b0, i_oh, 1'b0};
    assign w_trial = {r_rem[REM_W-2:0], r_num[NUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= WC_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
    end

    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_quot  = r_quot;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        case (r_state)
            WC_LOAD: begin
                n_num   = NUM_W'({(2 * DW)'(i_ow) * (2 * DW)'(i_th), 1'b0})
                          + NUM_W'(i_oh);
                n_quot  = '0;
                n_rem   = '0;
                n_cnt   = CNT_W'(NUM_W - 1);
                n_state = WC_RUN;
            end
            WC_RUN: begin
                n_num = {r_num[NUM_W-2:0], 1'b0};
                if (w_trial >= w_den) begin
                    n_rem  = w_trial - w_den;
                    n_quot = {r_quot[NUM_W-2:0], 1'b1};
                end else begin
                    n_rem  = w_trial;
                    n_quot = {r_quot[NUM_W-2:0], 1'b0};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = WC_DONE;
                end
            end
            WC_DONE: begin
                n_state = WC_DONE;
            end
            default: begin
                n_state = WC_LOAD;
            end
        endcase
        if (i_start) begin
            n_state = WC_LOAD;
        end
    end

    assign o_sw   = (r_quot == '0) ? SW_W'(1) : SW_W'(r_quot);
    assign o_busy = (r_state != WC_DONE) || i_start;

endmodule

FILE: rtl/rspa_div_pipe.sv
module rspa_div_pipe #(
    parameter int NW  = 43,
    parameter int DVW = 29,
    parameter int QB  = 14
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic           i_tag,
    input  logic [NW-1:0]  i_num,
    input  logic [DVW-1:0] i_den,
    output logic           o_valid,
    output logic           o_tag,
    output logic [QB-1:0]  o_quot
);
    import rspa_pkg::*;

    localparam int XW = ((NW > DVW + QB) ? NW : DVW + QB) + 1;

    logic [XW-1:0] r_rem [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    logic          r_v   [QB+1];
    logic          r_tag [QB+1];
    logic          r_sat [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= XW'(i_num);
            r_sat[0] <= XW'(i_num) >= (XW'(i_den) << QB);
            r_q[0]   <= '0;
            r_tag[0] <= i_tag;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_stage
        localparam int B = QB - j;
        logic [XW-1:0] n_shift;
        logic          n_ge;

        assign n_shift = XW'(i_den) << B;
        assign n_ge    = r_rem[j-1] >= n_shift;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= n_ge ? (r_rem[j-1] - n_shift) : r_rem[j-1];
                r_q[j]   <= r_q[j-1] | (n_ge ? (QB'(1) << B) : QB'(0));
                r_sat[j] <= r_sat[j-1];
                r_tag[j] <= r_tag[j-1];
            end
        end
    end

    assign o_valid = r_v[QB];
    assign o_tag   = r_tag[QB];
    assign o_quot  = r_sat[QB] ? '1 : r_q[QB];

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import rspa_pkg::*;

    localparam int MAXD = 16384;
    localparam int LATENCY = 18;
    localparam longint LIMIT = 2000000;

    class addr_scoreboard;
        t_out pending[$];
        int errors;
        int checked;
        logic [14:0] fw, fh, sh;
        logic [1:0] tn;

        function void set_reg(logic [1:0] idx, logic [14:0] v);
            case (idx)
                REG_FRAME_WIDTH: fw = v;
                REG_FRAME_HEIGHT: fh = v;
                REG_TURN: tn = v[1:0];
                default: sh = v;
            endcase
        endfunction

        function longint eff(logic [14:0] v);
            if (v == 0) return 1;
            if (v > MAXD) return MAXD;
            return v;
        endfunction

        function void note_input(t_in d);
            longint w, h, th, ow, oh, sw, sx, sy, rx, ry, c, r;
            t_out e;
            w = eff(fw);
            h = eff(fh);
            th = eff(sh);
            c = d.col;
            r = d.row;
            ow = (tn == TURN_90 || tn == TURN_270) ? h : w;
            oh = (tn == TURN_90 || tn == TURN_270) ? w : h;
            sw = (2 * ow * th + oh) / (2 * oh);
            if (sw < 1) sw = 1;
            sy = r * oh / th;
            if (sy > oh - 1) sy = oh - 1;
            sx = c * ow / sw;
            if (sx > ow - 1) sx = ow - 1;
            case (tn)
                TURN_90: begin rx = sy; ry = h - 1 - sx; end
                TURN_180: begin rx = w - 1 - sx; ry = h - 1 - sy; end
                TURN_270: begin rx = w - 1 - sy; ry = sx; end
                default: begin rx = sx; ry = sy; end
            endcase
            e.raw_col = rx[13:0];
            e.raw_row = ry[13:0];
            e.raw_index = 28'(ry * w + rx);
            e.scaled_width = 29'(sw);
            e.in_range = (c < sw && r < th);
            pending.insert(pending.size(), e);
        endfunction

        function void check_result(t_out a);
            t_out e;
            checked++;
            if (pending.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.raw_col !== e.raw_col) begin
                $error("raw_col expected %0d actual %0d", e.raw_col, a.raw_col); errors++;
            end
            if (a.raw_row !== e.raw_row) begin
                $error("raw_row expected %0d actual %0d", e.raw_row, a.raw_row); errors++;
            end
            if (a.raw_index !== e.raw_index) begin
                $error("raw_index expected %0d actual %0d", e.raw_index, a.raw_index);
                errors++;
            end
            if (a.scaled_width !== e.scaled_width) begin
                $error("scaled_width expected %0d actual %0d", e.scaled_width,
                       a.scaled_width);
                errors++;
            end
            if (a.in_range !== e.in_range) begin
                $error("in_range expected %0d actual %0d", e.in_range, a.in_range); errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [1:0] i_cfg_index = 0;
    logic [14:0] i_cfg_data = 0;
    logic i_in_valid = 0;
    logic o_in_ready;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 0;
    t_out o_out_data;

    addr_scoreboard sb;
    longint cycles = 0;
    bit long_hold = 0;
    bit stall_on = 1;

    rotate_scale_pixel_address_top dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
        if (long_hold) i_out_ready <= 0;
        else if (!stall_on) i_out_ready <= 1;
        else i_out_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic write_reg(logic [1:0] idx, logic [14:0] v);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic configure(logic [14:0] w, logic [14:0] h, logic [1:0] t,
                             logic [14:0] s);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_TURN, t);
        write_reg(REG_SCALED_HEIGHT, s);
        i_cfg_we <= 0;
    endtask

    task automatic send(logic [27:0] c, logic [13:0] r);
        i_in_valid <= 1;
        i_in_data <= '{col: c, row: r};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(i_in_data);
    endtask

    task automatic idle_gap(int n);
        i_in_valid <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    function automatic logic [14:0] rand_dim();
        case ($urandom_range(0, 9))
            0: return 15'($urandom_range(0, 32767));
            1: return 0;
            2: return 15'(MAXD);
            3: return 15'($urandom_range(MAXD, 32767));
            default: return 15'($urandom_range(1, 64));
        endcase
    endfunction

    task automatic random_item(longint sw, int sh);
        logic [27:0] c;
        logic [13:0] r;
        case ($urandom_range(0, 7))
            0: c = 28'($urandom);
            1: c = 28'(sw + $urandom_range(0, 3));
            default: c = 28'($urandom_range(0, (sw > 2000) ? 2000 : int'(sw) + 1));
        endcase
        if ($urandom_range(0, 7) == 0) r = 14'($urandom);
        else r = 14'($urandom_range(0, sh + 1));
        send(c, r);
    endtask

    initial begin
        longint swv;
        int shv;
        sb = new();
        sb.fw = 1920; sb.fh = 1080; sb.tn = TURN_NONE; sb.sh = 1080;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send(0, 0);
        send(1919, 1079);
        send(28'hFFFFFFF, 14'h3FFF);
        send(1920, 1080);
        for (int t = 0; t < 4; t++) begin
            configure(15'd7, 15'd5, 2'(t), 15'd3);
            send(0, 0);
            send(4, 2);
            send(28'hFFFFFFF, 14'h3FFF);
        end
        configure(0, 15'h7FFF, TURN_90, 0);
        send(0, 0); send(1, 0); send(5, 5);
        configure(15'h7FFF, 1, TURN_270, 15'h7FFF);
        send(28'hFFFFFF0, 16383); send(0, 16383);
        configure(MAXD, MAXD, TURN_180, 1);
        send(0, 0); send(2, 1);

        for (int ph = 0; ph < 20; ph++) begin
            logic [14:0] w, h, s;
            longint ow, oh;
            w = rand_dim(); h = rand_dim(); s = rand_dim();
            configure(w, h, 2'($urandom_range(0, 3)), s);
            ow = sb.eff(sb.tn[0] ? h : w);
            oh = sb.eff(sb.tn[0] ? w : h);
            shv = int'(sb.eff(s));
            swv = (2 * ow * shv + oh) / (2 * oh);
            if (swv < 1) swv = 1;
            stall_on = (ph % 4 != 1);
            for (int k = 0; k < 56;) begin
                int burst;
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && k < 56; b++, k++) random_item(swv, shv);
                if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 5));
            end
            if (ph == 5) begin
                fork
                    begin
                        long_hold = 1;
                        repeat (200) @(posedge i_clk);
                        long_hold = 0;
                    end
                    for (int k = 0; k < 40; k++) random_item(swv, shv);
                join
            end
            if (ph == 9) begin
                idle_gap(1);
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
        end

        drain();
        $display("Checked %0d address results over 20 random and 8 directed settings,",
                 sb.checked);
        $display("covering all turns, saturated sizes, out-of-range coordinates and stalls.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

FILE: files.f
rtl/rspa_pkg.sv
rtl/rspa_width_calc.sv
rtl/rspa_div_pipe.sv
rtl/rotate_scale_pixel_address_top.sv
tb/tb.sv
